@@ rtl/core/rotated_rect_corners_top_assert.svh @@
// ----------------------------------------------------------------------------
// rotated rectangle corners: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ROTATED_RECT_CORNERS_TOP_ASSERT_SVH
`define ROTATED_RECT_CORNERS_TOP_ASSERT_SVH

// same-cycle implication
`define RRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rotated rect corners check failed");

// next-cycle implication
`define RRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rotated rect corners check failed");

`endif

@@ rtl/core/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// types and constants of the rotated rectangle corner transform
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_LOG2        = $clog2(SINE_TABLE_DEPTH);
	localparam int CORDIC_STEPS     = 16;
	localparam int PIPE_DEPTH       = CORDIC_STEPS + 5;

	localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] RECT_RESET = 12'd64;

	typedef logic signed [15:0] coord_t;
	typedef logic [15:0]        angle_t;
	typedef logic signed [15:0] trig_t;
	typedef logic signed [31:0] cordic_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		logic   flip;
	} side_t;

endpackage

`default_nettype wire

@@ rtl/core/rrc_if.sv @@
// ----------------------------------------------------------------------------
// rrc channels
// ready/valid channels for rectangle requests and corner results
// ----------------------------------------------------------------------------
`default_nettype none

interface rrc_rect_if;
	logic            valid;
	logic            ready;
	rrc_pkg::coord_t center_x;
	rrc_pkg::coord_t center_y;
	rrc_pkg::angle_t rotation;

	modport source (output valid, output center_x, output center_y, output rotation,
		input ready);
	modport sink (input valid, input center_x, input center_y, input rotation,
		output ready);
endinterface

interface rrc_quad_if;
	logic            valid;
	logic            ready;
	rrc_pkg::coord_t top_left_x;
	rrc_pkg::coord_t top_left_y;
	rrc_pkg::coord_t top_right_x;
	rrc_pkg::coord_t top_right_y;
	rrc_pkg::coord_t bottom_left_x;
	rrc_pkg::coord_t bottom_left_y;
	rrc_pkg::coord_t bottom_right_x;
	rrc_pkg::coord_t bottom_right_y;

	modport source (output valid, output top_left_x, output top_left_y,
		output top_right_x, output top_right_y, output bottom_left_x,
		output bottom_left_y, output bottom_right_x, output bottom_right_y,
		input ready);
	modport sink (input valid, input top_left_x, input top_left_y,
		input top_right_x, input top_right_y, input bottom_left_x,
		input bottom_left_y, input bottom_right_x, input bottom_right_y,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/rotated_rect_corners_top.sv @@
// ----------------------------------------------------------------------------
// rotated_rect_corners_top
// Corner transform for rotated sprite quads.
//
// rect carries one rectangle per transfer: center (Q12.4) and a 16-bit binary
// angle. quad returns the four corners, each saturated to Q12.4. The width
// and height come from the config write port (index 0 width, 1 height, whole
// pixels); write them only while no item is in flight.
//
// The angle is quantized to the sine table depth in an input stage and turned
// into sine and cosine by a 16-stage CORDIC pipeline, one iteration per stage.
// After it come a round/clamp stage, a multiply stage, a sum/round stage and
// the output register: 21 stages in all.
// One rectangle enters per cycle, sustained, while quad is ready.
//
// Each stage holds its own valid bit and moves on when the next stage is empty
// or moving, so bubbles close up. When quad stalls the output register holds,
// the stages behind it fill, and rect.ready falls once every stage is full.
// Reset clears all valid bits and sets width and height to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_rect_corners_top (
	input  logic                             clk,
	input  logic                             arst_n,
	rrc_rect_if.sink                         rect,
	rrc_quad_if.source                       quad,
	input  logic                             cfg_we,
	input  logic [rrc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int L  = rrc_pkg::SINE_LOG2;
	localparam int KW = 17 + L;
	localparam int N  = rrc_pkg::CORDIC_STEPS;

	function automatic rrc_pkg::trig_t round_clamp(input rrc_pkg::cordic_t v,
		input logic neg);
		logic signed [32:0] r;
		logic signed [16:0] t;
		rrc_pkg::trig_t     c;
		r = {v[31], v} + 33'sd32768;
		t = r[32:16];
		if (t > 17'sd16384)
			c = 16'sd16384;
		else if (t < -17'sd16384)
			c = -16'sd16384;
		else
			c = t[15:0];
		return neg ? -c : c;
	endfunction

	function automatic rrc_pkg::coord_t sat16(input logic signed [19:0] v);
		rrc_pkg::coord_t r;
		if (v > 20'sd32767)
			r = 16'sh7fff;
		else if (v < -20'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [18:0] round14(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic sub);
		logic signed [32:0] s;
		if (sub)
			s = {a[31], a} - {b[31], b} + 33'sd8192;
		else
			s = {a[31], a} + {b[31], b} + 33'sd8192;
		return s[32:14];
	endfunction

	function automatic logic signed [19:0] add_ext(input rrc_pkg::coord_t c,
		input logic signed [18:0] d, input logic sub);
		logic signed [19:0] ce;
		logic signed [19:0] de;
		ce = {{4{c[15]}}, c};
		de = {d[18], d};
		return sub ? ce - de : ce + de;
	endfunction

	// config registers
	logic [rrc_pkg::CFG_DATA_W-1:0] rect_width_q;
	logic [rrc_pkg::CFG_DATA_W-1:0] rect_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_width_q  <= rrc_pkg::RECT_RESET;
			rect_height_q <= rrc_pkg::RECT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				rrc_pkg::REG_RECT_WIDTH:  rect_width_q  <= cfg_data;
				rrc_pkg::REG_RECT_HEIGHT: rect_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	logic         en_s1, en_s18, en_s19, en_s20, en_s21;
	logic         vld_s1, vld_s18, vld_s19, vld_s20, vld_s21;
	logic [N-1:0] cor_en;
	logic [N-1:0] cor_vld_s;

	assign en_s21 = !vld_s21 || quad.ready;
	assign en_s20 = !vld_s20 || en_s21;
	assign en_s19 = !vld_s19 || en_s20;
	assign en_s18 = !vld_s18 || en_s19;
	assign en_s1  = !vld_s1 || cor_en[0];
	assign rect.ready = en_s1;

	// stage 1: angle quantization and half-turn reduction
	logic [KW-1:0]     k_sum;
	logic [L-1:0]      k_idx;
	logic [31:0]       phase;
	rrc_pkg::cordic_t  z_s1;
	rrc_pkg::side_t    side_s1;

	assign k_sum = {1'b0, rect.rotation, {L{1'b0}}} + KW'(32768);
	assign k_idx = k_sum[15+L:16];
	assign phase = {k_idx, {(32-L){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en_s1)
			vld_s1 <= rect.valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			z_s1         <= {phase[30], phase[30:0]};
			side_s1.flip <= phase[31] ^ phase[30];
			side_s1.cx   <= rect.center_x;
			side_s1.cy   <= rect.center_y;
		end
	end

	// cordic stages, one iteration each
	rrc_pkg::cordic_t cor_x_s    [N];
	rrc_pkg::cordic_t cor_y_s    [N];
	rrc_pkg::cordic_t cor_z_s    [N];
	rrc_pkg::side_t   cor_side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_cordic
		rrc_pkg::cordic_t x_in, y_in, z_in;
		rrc_pkg::side_t   side_in;
		logic             vld_in, en_next;

		if (i == 0) begin : g_first
			assign x_in    = rrc_pkg::CORDIC_START;
			assign y_in    = '0;
			assign z_in    = z_s1;
			assign side_in = side_s1;
			assign vld_in  = vld_s1;
		end else begin : g_rest
			assign x_in    = cor_x_s[i-1];
			assign y_in    = cor_y_s[i-1];
			assign z_in    = cor_z_s[i-1];
			assign side_in = cor_side_s[i-1];
			assign vld_in  = cor_vld_s[i-1];
		end

		if (i == N - 1) begin : g_last
			assign en_next = en_s18;
		end else begin : g_mid
			assign en_next = cor_en[i+1];
		end

		assign cor_en[i] = !cor_vld_s[i] || en_next;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cor_vld_s[i] <= 1'b0;
			else if (cor_en[i])
				cor_vld_s[i] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (cor_en[i]) begin
				if (!z_in[31]) begin
					cor_x_s[i] <= x_in - (y_in >>> i);
					cor_y_s[i] <= y_in + (x_in >>> i);
					cor_z_s[i] <= z_in - $signed(rrc_pkg::ATAN_TURNS[i]);
				end else begin
					cor_x_s[i] <= x_in + (y_in >>> i);
					cor_y_s[i] <= y_in - (x_in >>> i);
					cor_z_s[i] <= z_in + $signed(rrc_pkg::ATAN_TURNS[i]);
				end
				cor_side_s[i] <= side_in;
			end
		end
	end

	// stage 18: round to Q1.14, clamp, undo half turn
	rrc_pkg::trig_t cos_s18, sin_s18;
	rrc_pkg::coord_t cx_s18, cy_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s18 <= 1'b0;
		else if (en_s18)
			vld_s18 <= cor_vld_s[N-1];
	end

	always_ff @(posedge clk) begin
		if (en_s18) begin
			cos_s18 <= round_clamp(cor_x_s[N-1], cor_side_s[N-1].flip);
			sin_s18 <= round_clamp(cor_y_s[N-1], cor_side_s[N-1].flip);
			cx_s18  <= cor_side_s[N-1].cx;
			cy_s18  <= cor_side_s[N-1].cy;
		end
	end

	// stage 19: half extent products
	logic signed [15:0] hw, hh;
	logic signed [31:0] wc_s19, hs_s19, ws_s19, hc_s19;
	rrc_pkg::coord_t    cx_s19, cy_s19;

	assign hw = $signed({1'b0, rect_width_q, 3'b000});
	assign hh = $signed({1'b0, rect_height_q, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s19 <= 1'b0;
		else if (en_s19)
			vld_s19 <= vld_s18;
	end

	always_ff @(posedge clk) begin
		if (en_s19) begin
			wc_s19 <= hw * cos_s18;
			hs_s19 <= hh * sin_s18;
			ws_s19 <= hw * sin_s18;
			hc_s19 <= hh * cos_s18;
			cx_s19 <= cx_s18;
			cy_s19 <= cy_s18;
		end
	end

	// stage 20: rotated extents rounded to Q.4
	logic signed [18:0] ax_s20, ay_s20, bx_s20, by_s20;
	rrc_pkg::coord_t    cx_s20, cy_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s20 <= 1'b0;
		else if (en_s20)
			vld_s20 <= vld_s19;
	end

	always_ff @(posedge clk) begin
		if (en_s20) begin
			ax_s20 <= round14(wc_s19, hs_s19, 1'b1);
			ay_s20 <= round14(ws_s19, hc_s19, 1'b0);
			bx_s20 <= round14(wc_s19, hs_s19, 1'b0);
			by_s20 <= round14(ws_s19, hc_s19, 1'b1);
			cx_s20 <= cx_s19;
			cy_s20 <= cy_s19;
		end
	end

	// stage 21: corners, saturated, output register
	rrc_pkg::coord_t tlx_s21, tly_s21, trx_s21, try_s21;
	rrc_pkg::coord_t blx_s21, bly_s21, brx_s21, bry_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s21 <= 1'b0;
		else if (en_s21)
			vld_s21 <= vld_s20;
	end

	always_ff @(posedge clk) begin
		if (en_s21) begin
			tlx_s21 <= sat16(add_ext(cx_s20, ax_s20, 1'b1));
			tly_s21 <= sat16(add_ext(cy_s20, ay_s20, 1'b1));
			trx_s21 <= sat16(add_ext(cx_s20, bx_s20, 1'b0));
			try_s21 <= sat16(add_ext(cy_s20, by_s20, 1'b0));
			blx_s21 <= sat16(add_ext(cx_s20, bx_s20, 1'b1));
			bly_s21 <= sat16(add_ext(cy_s20, by_s20, 1'b1));
			brx_s21 <= sat16(add_ext(cx_s20, ax_s20, 1'b0));
			bry_s21 <= sat16(add_ext(cy_s20, ay_s20, 1'b0));
		end
	end

	assign quad.valid          = vld_s21;
	assign quad.top_left_x     = tlx_s21;
	assign quad.top_left_y     = tly_s21;
	assign quad.top_right_x    = trx_s21;
	assign quad.top_right_y    = try_s21;
	assign quad.bottom_left_x  = blx_s21;
	assign quad.bottom_left_y  = bly_s21;
	assign quad.bottom_right_x = brx_s21;
	assign quad.bottom_right_y = bry_s21;

endmodule

`default_nettype wire

@@ rtl/core/rrc_checker.sv @@
// ----------------------------------------------------------------------------
// rrc_checker
// port-level checks on the rotated rectangle corner transform
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotated_rect_corners_top_assert.svh"

module rrc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rect_valid,
	input  logic         rect_ready,
	input  logic         quad_valid,
	input  logic         quad_ready,
	input  logic [127:0] quad_data
);

	logic [5:0] inflight_q;
	logic       rect_xfer, quad_xfer;

	assign rect_xfer = rect_valid && rect_ready;
	assign quad_xfer = quad_valid && quad_ready;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (rect_xfer && !quad_xfer)
			inflight_q <= inflight_q + 6'd1;
		else if (!rect_xfer && quad_xfer)
			inflight_q <= inflight_q - 6'd1;
	end

	`RRC_ASSERT_NEXT(a_valid_hold, clk, arst_n, quad_valid && !quad_ready, quad_valid)
	`RRC_ASSERT_NEXT(a_data_hold, clk, arst_n, quad_valid && !quad_ready, $stable(quad_data))
	`RRC_ASSERT_NOW(a_no_phantom, clk, arst_n, inflight_q == 6'd0, !quad_valid)
	`RRC_ASSERT_NOW(a_depth, clk, arst_n, 1'b1, inflight_q <= 6'(rrc_pkg::PIPE_DEPTH))
	`RRC_ASSERT_NOW(a_full_stall, clk, arst_n, !rect_ready, quad_valid && !quad_ready)

endmodule

bind rotated_rect_corners_top rrc_checker u_rrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rect_valid (rect.valid),
	.rect_ready (rect.ready),
	.quad_valid (quad.valid),
	.quad_ready (quad.ready),
	.quad_data  ({quad.top_left_x, quad.top_left_y, quad.top_right_x, quad.top_right_y,
		quad.bottom_left_x, quad.bottom_left_y, quad.bottom_right_x, quad.bottom_right_y})
);

`default_nettype wire

@@ verif/rotated_rect_corners_top_tb.sv @@
// ----------------------------------------------------------------------------
// rotated_rect_corners_top_tb
// Self-checking bench for the rotated rectangle corner transform. Rectangles
// are sent over the rect channel and every corner set that comes back on the
// quad channel is checked against a fixed-point CORDIC predictor kept in the
// bench. Directed items cover angle quadrant edges, angle wrap, zero and full
// size, and saturation; random items run under three idling patterns with
// width and height rewritten between blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rotated_rect_corners_top_tb;
	import rrc_pkg::coord_t;
	import rrc_pkg::angle_t;
	import rrc_pkg::CFG_IDX_W;
	import rrc_pkg::CFG_DATA_W;
	import rrc_pkg::REG_RECT_WIDTH;
	import rrc_pkg::REG_RECT_HEIGHT;

	localparam int     TRIG_DEPTH   = 1024;
	localparam int     ROT_STEPS    = 16;
	localparam longint ROT_START    = 64'sd652032874;
	localparam int     PIPE_LAT     = 21;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [31:0] ARC_STEP [ROT_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	// index 0 top_left_x .. index 7 bottom_right_y
	typedef logic [7:0][15:0] corners_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rrc_rect_if rect_ch ();
	rrc_quad_if quad_ch ();

	rotated_rect_corners_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rect     (rect_ch),
		.quad     (quad_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	logic [11:0] width_px  = 12'd64;
	logic [11:0] height_px = 12'd64;
	corners_t corner_q [$];
	int fail_count = 0;
	int src_idle = 0;
	int snk_idle = 0;
	int src_burst = 0;
	int snk_burst = 0;
	string field_name [8] = '{"top_left_x", "top_left_y", "top_right_x", "top_right_y",
		"bottom_left_x", "bottom_left_y", "bottom_right_x", "bottom_right_y"};

	always #4 clk = ~clk;

	function automatic longint clamp_range(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [15:0] sat_q12(longint v);
		return 16'(clamp_range(v, -32768, 32767));
	endfunction

	function automatic corners_t rotate_corners(coord_t cx, coord_t cy, angle_t rot);
		longint k, x, y, z, dx, dy, c, s, hw, hh, ax, ay, bx, by, px, py;
		logic [31:0] phase;
		logic flip;
		corners_t res;
		k = (longint'(rot) * TRIG_DEPTH + 32768) >>> 16;
		if (k >= TRIG_DEPTH)
			k = 0;
		phase = 32'((k << 32) / TRIG_DEPTH);
		flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
		if (flip)
			phase = phase - 32'h80000000;
		z = longint'($signed(phase));
		x = ROT_START;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ARC_STEP[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ARC_STEP[i]);
			end
		end
		c = clamp_range((x + 32768) >>> 16, -16384, 16384);
		s = clamp_range((y + 32768) >>> 16, -16384, 16384);
		if (flip) begin
			c = -c;
			s = -s;
		end
		hw = longint'(width_px) * 8;
		hh = longint'(height_px) * 8;
		ax = (hw * c - hh * s + 8192) >>> 14;
		ay = (hw * s + hh * c + 8192) >>> 14;
		bx = (hw * c + hh * s + 8192) >>> 14;
		by = (hw * s - hh * c + 8192) >>> 14;
		px = longint'(cx);
		py = longint'(cy);
		res[0] = sat_q12(px - ax);
		res[1] = sat_q12(py - ay);
		res[2] = sat_q12(px + bx);
		res[3] = sat_q12(py + by);
		res[4] = sat_q12(px - bx);
		res[5] = sat_q12(py - by);
		res[6] = sat_q12(px + ax);
		res[7] = sat_q12(py + ay);
		return res;
	endfunction

	// random stall decision with occasional stretches of no stall
	function automatic bit hold_cycle(inout int burst, input int pct);
		if (burst > 0) begin
			burst--;
			return 1'b0;
		end
		if ($urandom_range(99) < 2) begin
			burst = $urandom_range(40, 10);
			return 1'b0;
		end
		return $urandom_range(99) < pct;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// called and returns at a falling edge; valid stays high for the next transfer
	task automatic send_rect(coord_t cx, coord_t cy, angle_t rot);
		while (hold_cycle(src_burst, src_idle)) begin
			rect_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rect_ch.valid    <= 1'b1;
		rect_ch.center_x <= cx;
		rect_ch.center_y <= cy;
		rect_ch.rotation <= rot;
		@(posedge clk);
		while (!rect_ch.ready)
			@(posedge clk);
		corner_q.push_back(rotate_corners(cx, cy, rot));
		@(negedge clk);
	endtask

	task automatic drain;
		rect_ch.valid <= 1'b0;
		while (corner_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_RECT_WIDTH)
			width_px = val;
		else if (idx == REG_RECT_HEIGHT)
			height_px = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		drain();
		write_reg(REG_RECT_WIDTH, w);
		write_reg(REG_RECT_HEIGHT, h);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_size();
		case ($urandom_range(7))
			0: return 12'd0;
			1: return 12'd1;
			2: return 12'd4095;
			3, 4: return 12'($urandom_range(64, 1));
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic test_reset_size;
		send_rect(16'sh0000, 16'sh0000, 16'd0);
		send_rect(16'sh0000, 16'sh0000, 16'd16384);
		send_rect(16'sh0000, 16'sh0000, 16'd32768);
		send_rect(16'sh0000, 16'sh0000, 16'd49152);
		// angle rounds up to a full turn and wraps
		send_rect(16'sh0000, 16'sh0000, 16'd65535);
		send_rect(16'sh7FFF, 16'sh7FFF, 16'd8192);
		send_rect(16'sh8000, 16'sh8000, 16'd40000);
		send_rect(16'sh0064, 16'shFF38, 16'd16351);
		send_rect(16'sh0064, 16'shFF38, 16'd16352);
		send_rect(16'shFFFF, 16'sh0001, 16'd49151);
	endtask

	task automatic test_zero_size;
		set_size(12'd0, 12'd100);
		send_rect(16'sh0123, 16'shFEDC, 16'd0);
		send_rect(16'sh0123, 16'shFEDC, 16'd12000);
		send_rect(16'sh7FFF, 16'sh8000, 16'd60000);
		set_size(12'd100, 12'd0);
		send_rect(16'sh0123, 16'shFEDC, 16'd0);
		send_rect(16'sh0123, 16'shFEDC, 16'd30000);
		set_size(12'd0, 12'd0);
		send_rect(16'sh8000, 16'sh7FFF, 16'd5000);
	endtask

	task automatic test_max_size;
		set_size(12'd4095, 12'd4095);
		send_rect(16'sh0000, 16'sh0000, 16'd0);
		send_rect(16'sh0000, 16'sh0000, 16'd8192);
		send_rect(16'sh7FFF, 16'sh8000, 16'd24576);
		send_rect(16'sh8000, 16'sh7FFF, 16'd57344);
	endtask

	task automatic test_min_size;
		set_size(12'd1, 12'd1);
		send_rect(16'sh0000, 16'sh0000, 16'd10923);
		send_rect(16'sh7FFF, 16'sh8000, 16'd43690);
	endtask

	task automatic test_spare_index;
		drain();
		write_reg(REG_SPARE_A, 12'hFFF);
		write_reg(REG_SPARE_B, 12'h000);
		send_rect(16'sh0400, 16'shFC00, 16'd20000);
		send_rect(16'shFC00, 16'sh0400, 16'd50000);
	endtask

	task automatic test_random(int src_pct, int snk_pct, int n_items);
		coord_t cx, cy;
		src_idle = src_pct;
		snk_idle = snk_pct;
		for (int blk = 0; blk < 4; blk++) begin
			set_size(pick_size(), pick_size());
			if ($urandom_range(2) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
			repeat (n_items / 4) begin
				if ($urandom_range(9) < 6) begin
					cx = 16'($urandom_range(8191) - 4096);
					cy = 16'($urandom_range(8191) - 4096);
				end else begin
					cx = 16'($urandom);
					cy = 16'($urandom);
				end
				send_rect(cx, cy, 16'($urandom));
			end
		end
	endtask

	initial begin
		quad_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			quad_ch.ready <= !hold_cycle(snk_burst, snk_idle);
		end
	end

	always @(posedge clk) begin : check_corners
		corners_t got;
		corners_t want;
		if (arst_n && quad_ch.valid && quad_ch.ready) begin
			got = {quad_ch.bottom_right_y, quad_ch.bottom_right_x,
				quad_ch.bottom_left_y, quad_ch.bottom_left_x,
				quad_ch.top_right_y, quad_ch.top_right_x,
				quad_ch.top_left_y, quad_ch.top_left_x};
			if (corner_q.size() == 0) begin
				report_mismatch("corner transfer with no rectangle outstanding");
			end else begin
				want = corner_q.pop_front();
				for (int i = 0; i < 8; i++)
					if (got[i] !== want[i])
						report_mismatch($sformatf("%s got %0d expected %0d",
							field_name[i], $signed(got[i]), $signed(want[i])));
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = '0;
		cfg_data         = '0;
		rect_ch.valid    = 1'b0;
		rect_ch.center_x = '0;
		rect_ch.center_y = '0;
		rect_ch.rotation = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle = 8;
		snk_idle = 85;
		test_reset_size();
		test_zero_size();
		test_max_size();
		test_min_size();
		test_spare_index();
		test_random(8, 85, 180);
		test_random(85, 8, 180);
		test_random(0, 0, 192);
		drain();
		if (fail_count == 0)
			$display("rotated_rect_corners_top regression: pass");
		else
			$display("rotated_rect_corners_top regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("rotated_rect_corners_top regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rrc_pkg.sv
rtl/core/rrc_if.sv
rtl/core/rotated_rect_corners_top.sv
rtl/core/rrc_checker.sv
verif/rotated_rect_corners_top_tb.sv
